[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define TCCW_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion, checked through reset as well
`define TCCW_ASSERT_RAW(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tccw_pkg.sv]
package tccw_pkg;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int ATTR_W  = 2 * COLOR_W;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int DATA_W  = CHAR_W + ATTR_W;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  char_code;
    logic [ATTR_W-1:0]  attr;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_RUN,
    BK_RD_WAIT,
    BK_BLANK
  } back_state_t;

endpackage

[rtl/tccw_ram.sv]
module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tccw_front.sv]
module tccw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tccw_pkg::OP_W-1:0]     in_operation,
  input  logic [tccw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tccw_pkg::COLOR_W-1:0]  in_foreground,
  input  logic [tccw_pkg::COLOR_W-1:0]  in_background,
  input  logic [tccw_pkg::COL_W-1:0]    in_column,
  input  logic [tccw_pkg::ROW_W-1:0]    in_row,
  input  logic                          init_busy,
  input  logic                          q_full,
  output logic                          push,
  output tccw_pkg::cmd_t                push_cmd
);

  import tccw_pkg::*;

  logic on_screen;

  assign on_screen = (32'(in_column) < COLUMNS) && (32'(in_row) < ROWS);
  assign in_ready  = !q_full && !init_busy;
  assign push      = in_valid && in_ready;

  always_comb begin
    push_cmd.char_code = in_char_code;
    push_cmd.attr      = {in_background, in_foreground};
    push_cmd.column    = in_column;
    push_cmd.row       = in_row;
    case (in_operation)
      OP_PUT:   push_cmd.kind = CMD_PUT;
      OP_WRITE: push_cmd.kind = on_screen ? CMD_WRITE : CMD_NOP;
      OP_READ:  push_cmd.kind = on_screen ? CMD_READ : CMD_NOP;
      default:  push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

[rtl/tccw_fifo.sv]
module tccw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tccw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output tccw_pkg::cmd_t pop_cmd
);

  import tccw_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  cmd_t            entry_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CW'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/tccw_back.sv]
module tccw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  tccw_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         init_busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tccw_pkg::DATA_W-1:0]  out_read_data,
  output logic [tccw_pkg::COL_W-1:0]   out_cursor_col,
  output logic [tccw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic                         out_cleared
);

  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CXW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RYW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW1   = CXW + 1;
  localparam int YW1   = RYW + 1;

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic [CXW-1:0]     cur_x_r, cur_x_nxt;
  logic [RYW-1:0]     cur_y_r, cur_y_nxt;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic               out_cleared_r;

  logic               slot_free;
  logic               sweep_last;
  logic [AW-1:0]      cell_addr;
  logic [AW-1:0]      put_addr;
  logic               is_nl;
  logic [XW1-1:0]     x_inc;
  logic               x_wrap;
  logic               adv_row;
  logic [YW1-1:0]     y_inc;
  logic               put_clear;

  logic               char_we, attr_we;
  logic [AW-1:0]      waddr;
  logic [CHAR_W-1:0]  char_wdata, char_rdata;
  logic [ATTR_W-1:0]  attr_wdata, attr_rdata;
  logic               load_out;
  logic [DATA_W-1:0]  ld_data;
  logic               ld_cleared;

  assign slot_free  = !out_valid_r || out_ready;
  assign sweep_last = (sweep_r == AW'(CELLS - 1));
  assign cell_addr  = AW'(32'(q_cmd.row) * COLUMNS + 32'(q_cmd.column));
  assign put_addr   = AW'(32'(cur_y_r) * COLUMNS + 32'(cur_x_r));
  assign is_nl      = (q_cmd.char_code == NEWLINE_CODE);
  assign x_inc      = XW1'(cur_x_r) + XW1'(1);
  assign x_wrap     = !is_nl && (32'(x_inc) >= COLUMNS);
  assign adv_row    = is_nl || x_wrap;
  assign y_inc      = YW1'(cur_y_r) + YW1'(adv_row);
  assign put_clear  = (32'(y_inc) >= ROWS);
  assign q_pop      = (state_r == BK_RUN) && q_valid && slot_free;
  assign init_busy  = (state_r == BK_INIT);

  tccw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (waddr),
    .wdata (char_wdata),
    .raddr (cell_addr),
    .rdata (char_rdata)
  );

  tccw_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (waddr),
    .wdata (attr_wdata),
    .raddr (cell_addr),
    .rdata (attr_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT: begin
        if (sweep_last) state_nxt = BK_RUN;
      end
      BK_RUN: begin
        if (q_pop) begin
          if (q_cmd.kind == CMD_READ) begin
            state_nxt = BK_RD_WAIT;
          end else if (q_cmd.kind == CMD_PUT && put_clear) begin
            state_nxt = BK_BLANK;
          end
        end
      end
      BK_RD_WAIT: state_nxt = BK_RUN;
      BK_BLANK: begin
        if (sweep_last) state_nxt = BK_RUN;
      end
      default: state_nxt = BK_INIT;
    endcase
  end

  always_comb begin
    char_we    = 1'b0;
    attr_we    = 1'b0;
    waddr      = sweep_r;
    char_wdata = '0;
    attr_wdata = '0;
    sweep_nxt  = sweep_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    load_out   = 1'b0;
    ld_data    = '0;
    ld_cleared = 1'b0;
    case (state_r)
      BK_INIT: begin
        char_we   = 1'b1;
        attr_we   = 1'b1;
        sweep_nxt = sweep_last ? '0 : sweep_r + AW'(1);
      end
      BK_RUN: begin
        if (q_pop) begin
          case (q_cmd.kind)
            CMD_PUT: begin
              char_we    = !is_nl;
              waddr      = put_addr;
              char_wdata = q_cmd.char_code;
              if (put_clear) begin
                cur_x_nxt = '0;
                cur_y_nxt = '0;
              end else begin
                cur_x_nxt = adv_row ? '0 : CXW'(x_inc);
                cur_y_nxt = RYW'(y_inc);
                load_out  = 1'b1;
              end
            end
            CMD_WRITE: begin
              char_we    = 1'b1;
              attr_we    = 1'b1;
              waddr      = cell_addr;
              char_wdata = q_cmd.char_code;
              attr_wdata = q_cmd.attr;
              load_out   = 1'b1;
            end
            CMD_READ: ;
            default: load_out = 1'b1;
          endcase
        end
      end
      BK_RD_WAIT: begin
        load_out = 1'b1;
        ld_data  = {attr_rdata, char_rdata};
      end
      BK_BLANK: begin
        char_we    = 1'b1;
        char_wdata = SPACE_CODE;
        sweep_nxt  = sweep_last ? '0 : sweep_r + AW'(1);
        if (sweep_last) begin
          load_out   = 1'b1;
          ld_cleared = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      sweep_r     <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r    <= ld_data;
      out_col_r     <= COL_W'(cur_x_nxt);
      out_row_r     <= ROW_W'(cur_y_nxt);
      out_cleared_r <= ld_cleared;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cleared    = out_cleared_r;

endmodule

[rtl/text_console_char_writer_top.sv]
// Text console of COLUMNS x ROWS cells (character byte low, attribute byte high).
// After reset the screen store is swept to zero, one cell per cycle, over all
// COLUMNS*ROWS cells (2000 at 80x25); in_ready stays low during that sweep.
// Beats go through a two-entry command queue to an execution stage that owns
// the screen memories and the cursor. Write-cell, put-character and no-op
// beats are done in the run state; read-cell also passes a read-wait state
// (registered memory read) that holds off the next beat, so writes sustain
// one beat per cycle while the output is free. A put-character running past
// the last row blanks every character to a space, one cell per cycle. Results
// sit in an output register, so the queue keeps filling while a result waits.
module text_console_char_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tccw_pkg::OP_W-1:0]     in_operation,
  input  logic [tccw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tccw_pkg::COLOR_W-1:0]  in_foreground,
  input  logic [tccw_pkg::COLOR_W-1:0]  in_background,
  input  logic [tccw_pkg::COL_W-1:0]    in_column,
  input  logic [tccw_pkg::ROW_W-1:0]    in_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tccw_pkg::DATA_W-1:0]   out_read_data,
  output logic [tccw_pkg::COL_W-1:0]    out_cursor_col,
  output logic [tccw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic                          out_cleared
);

  import tccw_pkg::*;

  logic  init_busy;
  logic  q_full;
  logic  push;
  cmd_t  push_cmd;
  logic  q_pop;
  logic  q_valid;
  cmd_t  q_cmd;

  tccw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_foreground (in_foreground),
    .in_background (in_background),
    .in_column     (in_column),
    .in_row        (in_row),
    .init_busy     (init_busy),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  tccw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  tccw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cleared    (out_cleared)
  );

endmodule

[rtl/tccw_checker.sv]
`include "assert_macros.svh"

module tccw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [tccw_pkg::OP_W-1:0]     in_operation,
  input logic [tccw_pkg::CHAR_W-1:0]   in_char_code,
  input logic [tccw_pkg::COLOR_W-1:0]  in_foreground,
  input logic [tccw_pkg::COLOR_W-1:0]  in_background,
  input logic [tccw_pkg::COL_W-1:0]    in_column,
  input logic [tccw_pkg::ROW_W-1:0]    in_row,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tccw_pkg::DATA_W-1:0]   out_read_data,
  input logic [tccw_pkg::COL_W-1:0]    out_cursor_col,
  input logic [tccw_pkg::ROW_W-1:0]    out_cursor_row,
  input logic                          out_cleared
);

  // stalled result beat holds
  `TCCW_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_cursor_col) && $stable(out_cursor_row) && $stable(out_cleared), "result beat changed while stalled")

  `TCCW_ASSERT_CLK(a_cursor_range, clk, rst_n, out_valid |-> (32'(out_cursor_col) < COLUMNS) && (32'(out_cursor_row) < ROWS), "cursor outside the screen")

  // a blanking beat always homes the cursor
  `TCCW_ASSERT_CLK(a_clear_home, clk, rst_n, out_valid && out_cleared |-> out_cursor_col == '0 && out_cursor_row == '0, "cleared beat with cursor away from home")

  // store sweep follows reset, no input taken
  `TCCW_ASSERT_RAW(a_init_blocks_input, clk, !rst_n |=> !in_ready, "input taken right after reset")

endmodule

bind text_console_char_writer_top tccw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tccw_checker (.*);
